// ===== src/id3tss_pkg.sv =====
// ----------------------------------------------------------------------------
// ID3 tag size scanner package
// Scan phases, result kind codes and header constants shared by the core.
// ----------------------------------------------------------------------------
package id3tss_pkg;

   typedef enum logic [4:0] {
      PH_PREFIX = 5'b00001,
      PH_HEADER = 5'b00010,
      PH_SKIP   = 5'b00100,
      PH_PAD    = 5'b01000,
      PH_DONE   = 5'b10000
   } phase_type;

   typedef logic [1:0] kind_type;

   localparam kind_type KIND_NONE     = 2'd0;
   localparam kind_type KIND_V1       = 2'd1;
   localparam kind_type KIND_V2       = 2'd2;
   localparam kind_type KIND_RESERVED = 2'd3;

   localparam int V1_TAG_SIZE = 128;
   localparam int HEADER_LEN  = 10;

   localparam logic [7:0] BYTE_FF     = 8'hff;
   localparam logic [7:0] FOOTER_FLAG = 8'h10;

   localparam logic [1:0] MATCH_BOTH = 2'b11;

   // expected prefix byte for the ID3v1 marker "TAG"
   function automatic logic [7:0] prefix_v1(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = 8'h54;
         2'd1:    b = 8'h41;
         2'd2:    b = 8'h47;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // expected prefix byte for the ID3v2 marker "ID3"
   function automatic logic [7:0] prefix_v2(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = 8'h49;
         2'd1:    b = 8'h44;
         2'd2:    b = 8'h33;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// ===== src/id3_tag_size_scanner_core.sv =====
// ----------------------------------------------------------------------------
// ID3 tag size scanner core
// Scans a byte stream framed by tlast and reports one tag kind and size per
// scan.
// ----------------------------------------------------------------------------
// One byte is taken in every cycle. Each byte updates the scan state in the
// same cycle and, when it settles the scan, loads the result register, so a
// result appears in the cycle after the byte that decides it. The input stalls
// only while a result sits in the result register and rsp_tready is low. A
// request with tlast always ends the scan with exactly one result and starts
// a new scan; bytes after the result up to tlast give nothing. The byte
// position and the tag size saturate at 2^SIZE_BITS - 1.
module id3_tag_size_scanner_core #(
   parameter int SIZE_BITS = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [7:0]                             req_tdata,   // data_byte[7:0]
   input  logic                                   req_tlast,   // last_byte
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [((2 + SIZE_BITS + 7) / 8) * 8 - 1:0] rsp_tdata
   // rsp_tdata: tag_kind[1:0], tag_size, zero fill
);

   localparam logic [SIZE_BITS - 1:0] SizeMax = '1;

   id3tss_pkg::phase_type phase_ff, phase_in;
   logic [SIZE_BITS - 1:0] pos_ff, pos_in;
   logic [SIZE_BITS - 1:0] acc_ff, acc_in;
   logic [1:0]             match_ff, match_in;
   logic                   ok_ff, ok_in;

   logic                   rsp_valid_ff;
   id3tss_pkg::kind_type   rsp_kind_ff;
   logic [SIZE_BITS - 1:0] rsp_size_ff;

   logic                   req_fire;
   logic                   res_load;
   id3tss_pkg::kind_type   res_kind;
   logic [SIZE_BITS - 1:0] res_size;
   logic [SIZE_BITS - 1:0] term;
   logic [1:0]             m;
   logic                   h;
   logic [SIZE_BITS - 1:0] a;

   function automatic logic [SIZE_BITS - 1:0] sat_inc(input logic [SIZE_BITS - 1:0] v);
      return (v == SizeMax) ? v : v + SIZE_BITS'(1);
   endfunction

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      acc_in   = acc_ff;
      match_in = match_ff;
      ok_in    = ok_ff;
      res_load = 1'b0;
      res_kind = id3tss_pkg::KIND_NONE;
      res_size = '0;
      term     = '0;
      m        = match_ff;
      h        = ok_ff;
      a        = acc_ff;

      unique case (phase_ff)
         id3tss_pkg::PH_PREFIX: begin
            if (req_tdata != id3tss_pkg::prefix_v1(pos_ff[1:0])) m[0] = 1'b0;
            if (req_tdata != id3tss_pkg::prefix_v2(pos_ff[1:0])) m[1] = 1'b0;
            match_in = m;
            if (m == 2'b00) begin
               res_load = 1'b1;
               phase_in = id3tss_pkg::PH_DONE;
            end else if (pos_ff >= SIZE_BITS'(2)) begin
               if (m[0]) begin
                  res_load = 1'b1;
                  res_kind = id3tss_pkg::KIND_V1;
                  res_size = SIZE_BITS'(id3tss_pkg::V1_TAG_SIZE);
                  phase_in = id3tss_pkg::PH_DONE;
               end else begin
                  phase_in = id3tss_pkg::PH_HEADER;
               end
            end
         end
         id3tss_pkg::PH_HEADER: begin
            case (pos_ff[3:0])
               4'd6:    term = SIZE_BITS'(req_tdata[6:0]) << 21;
               4'd7:    term = SIZE_BITS'(req_tdata[6:0]) << 14;
               4'd8:    term = SIZE_BITS'(req_tdata[6:0]) << 7;
               4'd9:    term = SIZE_BITS'(req_tdata[6:0]);
               default: term = '0;
            endcase
            case (pos_ff[3:0]) inside
               4'd3, 4'd4: begin
                  if (req_tdata == id3tss_pkg::BYTE_FF) h = 1'b0;
               end
               4'd5: begin
                  a = ((req_tdata & id3tss_pkg::FOOTER_FLAG) != 8'h00)
                     ? SIZE_BITS'(id3tss_pkg::HEADER_LEN) : '0;
               end
               4'd6, 4'd7, 4'd8, 4'd9: begin
                  if (req_tdata[7]) h = 1'b0;
                  a = a + term;
               end
               default: ;
            endcase
            if (pos_ff[3:0] == 4'd9) begin
               if (!h) begin
                  res_load = 1'b1;
                  phase_in = id3tss_pkg::PH_DONE;
               end else begin
                  a        = a + SIZE_BITS'(id3tss_pkg::HEADER_LEN);
                  phase_in = id3tss_pkg::PH_SKIP;
               end
            end
            ok_in  = h;
            acc_in = a;
         end
         id3tss_pkg::PH_SKIP: begin
            if (pos_ff == acc_ff) begin
               if (req_tdata == 8'h00) begin
                  acc_in   = sat_inc(acc_ff);
                  phase_in = id3tss_pkg::PH_PAD;
               end else begin
                  res_load = 1'b1;
                  res_kind = id3tss_pkg::KIND_V2;
                  res_size = acc_ff;
                  phase_in = id3tss_pkg::PH_DONE;
               end
            end
         end
         id3tss_pkg::PH_PAD: begin
            if (req_tdata == 8'h00) begin
               acc_in = sat_inc(acc_ff);
            end else begin
               res_load = 1'b1;
               res_kind = id3tss_pkg::KIND_V2;
               res_size = acc_ff;
               phase_in = id3tss_pkg::PH_DONE;
            end
         end
         id3tss_pkg::PH_DONE: ;
         default: ;
      endcase

      if (req_tlast) begin
         if (!res_load && phase_in != id3tss_pkg::PH_DONE) begin
            res_load = 1'b1;
            if (phase_in == id3tss_pkg::PH_SKIP || phase_in == id3tss_pkg::PH_PAD) begin
               res_kind = id3tss_pkg::KIND_V2;
               res_size = acc_in;
            end
         end
         phase_in = id3tss_pkg::PH_PREFIX;
         pos_in   = '0;
         acc_in   = '0;
         match_in = id3tss_pkg::MATCH_BOTH;
         ok_in    = 1'b1;
      end else begin
         pos_in = sat_inc(pos_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= id3tss_pkg::PH_PREFIX;
         pos_ff   <= '0;
         acc_ff   <= '0;
         match_ff <= id3tss_pkg::MATCH_BOTH;
         ok_ff    <= 1'b1;
      end else if (req_fire) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         acc_ff   <= acc_in;
         match_ff <= match_in;
         ok_ff    <= ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire && res_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && res_load) begin
         rsp_kind_ff <= res_kind;
         rsp_size_ff <= res_size;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      rsp_tdata                 = '0;
      rsp_tdata[1:0]            = rsp_kind_ff;
      rsp_tdata[2 +: SIZE_BITS] = rsp_size_ff;
   end

`ifndef ASSERT_OFF
   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_kind_ff != id3tss_pkg::KIND_RESERVED)
      else $error("reserved tag kind in result register");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == id3tss_pkg::KIND_NONE |-> rsp_size_ff == '0)
      else $error("no-tag result with nonzero size");

   a_v1_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == id3tss_pkg::KIND_V1
      |-> rsp_size_ff == SIZE_BITS'(id3tss_pkg::V1_TAG_SIZE))
      else $error("ID3v1 result with wrong size");

   a_v2_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == id3tss_pkg::KIND_V2
      |-> rsp_size_ff >= SIZE_BITS'(id3tss_pkg::HEADER_LEN))
      else $error("ID3v2 result shorter than its header");

   a_prefix_pos: assert property (@(posedge clock) disable iff (reset)
      phase_ff == id3tss_pkg::PH_PREFIX |-> pos_ff < SIZE_BITS'(3))
      else $error("prefix phase past third byte");

   a_hold_state: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(phase_ff) && $stable(pos_ff))
      else $error("scan state moved without a request");
`endif

endmodule

// ===== test/tb_id3_tag_size_scanner_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ID3 tag size scanner core testbench
// Sends byte scans framed by tlast: directed cases first, then random scans
// that are mostly well-formed tags. It varies sender gaps and receiver stalls
// and holds the result side off long enough to back up the input. Each
// result is checked against an in-bench model of the scan.
// ----------------------------------------------------------------------------
module tb_id3_tag_size_scanner_core;

   localparam int          CYCLE_LIMIT     = 400000;
   localparam int          RANDOM_BUDGET   = 240;
   localparam logic [7:0]  SIZE_BYTE_LIMIT = 8'h80;
   localparam logic [23:0] V1_MARK         = {8'h47, 8'h41, 8'h54};
   localparam logic [23:0] V2_MARK         = {8'h33, 8'h44, 8'h49};

   typedef struct {
      id3tss_pkg::kind_type kind;
      logic [31:0]          size;
   } tag_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // data_byte[7:0]
   logic        req_tlast = 1'b0;    // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;           // tag_kind[1:0], tag_size[33:2], zero fill

   // scan model state
   id3tss_pkg::phase_type scan_phase;
   logic [31:0]           scan_pos;
   logic [31:0]           tag_len;
   logic [1:0]            marker_live;
   logic                  header_good;

   tag_result_type expected_tags[$];
   logic [7:0]     scan_bytes[$];
   int             error_count = 0;
   int             sent_count = 0;
   int             send_idle_pct = 0;
   int             recv_stall_pct = 0;
   int             hold_cycles = 0;

   id3_tag_size_scanner_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb_id3_tag_size_scanner_core failed");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == 32'hffff_ffff) ? v : v + 32'd1;
   endfunction

   function automatic void restart_scan();
      scan_phase  = id3tss_pkg::PH_PREFIX;
      scan_pos    = '0;
      tag_len     = '0;
      marker_live = id3tss_pkg::MATCH_BOTH;
      header_good = 1'b1;
   endfunction

   task automatic predict_tag(input logic [7:0] d, input logic last);
      logic [31:0]    p;
      logic           found;
      tag_result_type r;
      p     = scan_pos;
      found = 1'b0;
      r     = '{id3tss_pkg::KIND_NONE, 32'd0};
      case (scan_phase)
         id3tss_pkg::PH_PREFIX: begin
            if (p < 3) begin
               if (d != V1_MARK[8 * p[1:0] +: 8]) marker_live[0] = 1'b0;
               if (d != V2_MARK[8 * p[1:0] +: 8]) marker_live[1] = 1'b0;
            end
            if (marker_live == 2'b00) begin
               found = 1'b1;
            end else if (p >= 2) begin
               if (marker_live[0]) begin
                  found = 1'b1;
                  r = '{id3tss_pkg::KIND_V1, id3tss_pkg::V1_TAG_SIZE};
               end else begin
                  scan_phase = id3tss_pkg::PH_HEADER;
               end
            end
         end
         id3tss_pkg::PH_HEADER: begin
            if (p == 3 || p == 4) begin
               if (d >= id3tss_pkg::BYTE_FF) header_good = 1'b0;
            end else if (p == 5) begin
               tag_len = ((d & id3tss_pkg::FOOTER_FLAG) != 0) ? id3tss_pkg::HEADER_LEN : 0;
            end else if (p >= 6 && p <= 9) begin
               if (d >= SIZE_BYTE_LIMIT) header_good = 1'b0;
               tag_len = tag_len + (32'(d[6:0]) << ((9 - p) * 7));
            end
            if (p >= 9) begin
               if (!header_good) begin
                  found = 1'b1;
               end else begin
                  tag_len    = tag_len + id3tss_pkg::HEADER_LEN;
                  scan_phase = id3tss_pkg::PH_SKIP;
               end
            end
         end
         id3tss_pkg::PH_SKIP: begin
            if (p == tag_len) begin
               if (d == 8'h00) begin
                  tag_len    = sat_inc(tag_len);
                  scan_phase = id3tss_pkg::PH_PAD;
               end else begin
                  found = 1'b1;
                  r = '{id3tss_pkg::KIND_V2, tag_len};
               end
            end
         end
         id3tss_pkg::PH_PAD: begin
            if (d == 8'h00) begin
               tag_len = sat_inc(tag_len);
            end else begin
               found = 1'b1;
               r = '{id3tss_pkg::KIND_V2, tag_len};
            end
         end
         default: ;
      endcase
      if (found) scan_phase = id3tss_pkg::PH_DONE;
      if (last) begin
         if (!found && scan_phase != id3tss_pkg::PH_DONE) begin
            found = 1'b1;
            if (scan_phase == id3tss_pkg::PH_SKIP || scan_phase == id3tss_pkg::PH_PAD)
               r = '{id3tss_pkg::KIND_V2, tag_len};
         end
         restart_scan();
      end else begin
         scan_pos = sat_inc(scan_pos);
      end
      if (found) expected_tags.push_back(r);
   endtask

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_byte(input logic [7:0] d, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      predict_tag(d, last);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic send_scan();
      foreach (scan_bytes[i]) send_byte(scan_bytes[i], i == scan_bytes.size() - 1);
      scan_bytes.delete();
   endtask

   task automatic build_v2_scan(input logic broken);
      logic [7:0] size_b[4];
      int         len;
      bit         big_size;
      scan_bytes = '{8'h49, 8'h44, 8'h33};
      scan_bytes.push_back(8'($urandom_range(0, 254)));
      scan_bytes.push_back(8'($urandom_range(0, 254)));
      scan_bytes.push_back(8'($urandom));
      big_size = ($urandom_range(3) == 0);
      for (int i = 0; i < 4; i++) begin
         size_b[i] = big_size ? 8'($urandom_range(0, 127)) : 8'h00;
      end
      if (!big_size) size_b[3] = 8'($urandom_range(0, 15));
      foreach (size_b[i]) scan_bytes.push_back(size_b[i]);
      if (broken) begin
         if ($urandom_range(1)) scan_bytes[$urandom_range(3, 4)] = id3tss_pkg::BYTE_FF;
         else scan_bytes[$urandom_range(6, 9)] |= SIZE_BYTE_LIMIT;
      end
      if (big_size) begin
         repeat ($urandom_range(0, 5)) scan_bytes.push_back(8'($urandom));
      end else begin
         len = size_b[3] + (((scan_bytes[5] & id3tss_pkg::FOOTER_FLAG) != 0)
               ? id3tss_pkg::HEADER_LEN : 0);
         repeat (len) scan_bytes.push_back(8'($urandom));
         repeat ($urandom_range(0, 4)) scan_bytes.push_back(8'h00);
         scan_bytes.push_back(8'($urandom_range(1, 255)));
         repeat ($urandom_range(0, 3)) scan_bytes.push_back(8'($urandom));
      end
   endtask

   task automatic build_scan();
      int sel;
      int cut;
      sel = $urandom_range(99);
      if (sel < 55) begin
         build_v2_scan(1'b0);
      end else if (sel < 65) begin
         build_v2_scan(1'b1);
      end else if (sel < 75) begin
         scan_bytes = '{8'h54, 8'h41, 8'h47};
         repeat ($urandom_range(0, 4)) scan_bytes.push_back(8'($urandom));
      end else begin
         scan_bytes.delete();
         if ($urandom_range(1)) scan_bytes.push_back($urandom_range(1) ? 8'h49 : 8'h54);
         repeat ($urandom_range(1, 6)) scan_bytes.push_back(8'($urandom));
      end
      // cut some scans short
      if ($urandom_range(99) < 15) begin
         cut = $urandom_range(1, scan_bytes.size());
         while (scan_bytes.size() > cut) void'(scan_bytes.pop_back());
      end
   endtask

   task automatic run_random_scans(input int budget);
      int start;
      start = sent_count;
      while (sent_count - start < budget) begin
         build_scan();
         send_scan();
      end
   endtask

   task automatic test_directed();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      scan_bytes = '{8'hff};
      send_scan();
      scan_bytes = '{8'h54, 8'h41, 8'h47};
      send_scan();
      scan_bytes = '{8'h54, 8'h41, 8'h47, 8'h00};
      send_scan();
      scan_bytes = '{8'h49, 8'h44};
      send_scan();
      scan_bytes = '{8'h49, 8'h44, 8'h33, 8'hfe, id3tss_pkg::BYTE_FF,
                     8'h00, 8'h7f, 8'h7f, 8'h7f, 8'h7f};
      send_scan();
      scan_bytes = '{8'h49, 8'h44, 8'h33, 8'h00, 8'h00, 8'h00,
                     8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      send_scan();
   endtask

   task automatic test_full_rate();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      run_random_scans(RANDOM_BUDGET);
   endtask

   task automatic test_sender_idle();
      send_idle_pct  = 75;
      recv_stall_pct = 0;
      run_random_scans(RANDOM_BUDGET);
   endtask

   task automatic test_receiver_stall();
      send_idle_pct  = 0;
      recv_stall_pct = 75;
      run_random_scans(RANDOM_BUDGET);
   endtask

   task automatic test_both_idle();
      send_idle_pct  = 13;
      recv_stall_pct = 13;
      run_random_scans(RANDOM_BUDGET);
   endtask

   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_cycles    = 400;
      run_random_scans(RANDOM_BUDGET);
   endtask

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      tag_result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_tags.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", rsp_tdata));
         end else begin
            e = expected_tags.pop_front();
            if (rsp_tdata[1:0] != e.kind)
               report_mismatch($sformatf("tag_kind %0d, expected %0d",
                                         rsp_tdata[1:0], e.kind));
            if (rsp_tdata[33:2] != e.size)
               report_mismatch($sformatf("tag_size %0d, expected %0d",
                                         rsp_tdata[33:2], e.size));
            if (rsp_tdata[39:34] != '0)
               report_mismatch($sformatf("fill bits %b not zero", rsp_tdata[39:34]));
         end
      end
   end

   initial begin
      restart_scan();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_full_rate();
      test_sender_idle();
      test_receiver_stall();
      test_both_idle();
      test_backpressure();
      req_tvalid <= 1'b0;
      while (expected_tags.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_id3_tag_size_scanner_core passed");
      end else begin
         $display("tb_id3_tag_size_scanner_core failed");
      end
      $finish;
   end

endmodule
